@@ rtl/mpg_pkg.sv @@
// Shared types and constants of the multimodal prior gradient core.
// Used by mpg_div, mpg_cell and multimodal_prior_gradient_core; no dependencies.
`default_nettype none

package mpg_pkg;

  localparam int PIX_W     = 16;
  localparam int SLP_W     = 17;
  localparam int GRAD_W    = 32;
  localparam int CURV_W    = 16;
  localparam int WORD_W    = 48;
  localparam int CFG_IDX_W = 3;
  localparam int DIVD_W    = 34;
  localparam int DIVS_W    = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE_COUNT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_WORD_FIRST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_WORD_LAST  = 3'd4;

  localparam logic [2:0]        MODE_COUNT_RESET = 3'd1;
  localparam logic [WORD_W-1:0] MODE_WORD_RESET  = 48'h0100_0100_0000;

  typedef struct packed {
    logic signed [PIX_W-1:0] pos;
    logic signed [PIX_W-1:0] ctr;
    logic signed [SLP_W-1:0] slp;
  } corner_t;

  typedef struct packed {
    logic                    valid;
    logic signed [PIX_W-1:0] pixel;
    logic                    last;
    logic                    found;
    logic signed [PIX_W-1:0] ctr;
    logic signed [SLP_W-1:0] slp;
  } stage_t;

endpackage

`default_nettype wire

@@ rtl/multimodal_prior_gradient_core.sv @@
// Multimodal prior gradient core: pixels pass a chain of 3*MAX_MODES-2 corner cells,
// then a multiply stage and an output register. Depends on mpg_pkg, mpg_cell, mpg_div.
// One pixel per cycle; a stalled result holds the pipeline.
// The corner table is rebuilt after reset and after each configuration write to an index up
// to CFG_MODE_WORD_LAST; s_axis_tready stays low meanwhile. Reset clears control state.
`default_nettype none

module multimodal_prior_gradient_core #(
  parameter int MAX_MODES = 4
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [mpg_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [mpg_pkg::WORD_W-1:0]          cfg_data_i,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // pixel_value[15:0]
  input  wire logic [mpg_pkg::PIX_W-1:0]           s_axis_tdata,
  input  wire logic                                s_axis_tlast,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // gradient[31:0], curvature[47:32]
  output logic [mpg_pkg::GRAD_W+mpg_pkg::CURV_W-1:0] m_axis_tdata,
  output logic                                     m_axis_tlast
);

  localparam int NC = 3 * MAX_MODES - 2;
  localparam int CW = (NC > 1) ? $clog2(NC) : 1;
  localparam int JW = $clog2(MAX_MODES + 1);
  localparam int IW = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
  localparam logic [3:0] MAXM = 4'(MAX_MODES);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_NEXT  = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_ADD   = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_WR0   = 4'd6;
  localparam logic [3:0] S_WR1   = 4'd7;
  localparam logic [3:0] S_WR2   = 4'd8;

  // Configuration registers.
  logic [2:0]                  mode_count_q;
  logic [mpg_pkg::WORD_W-1:0]  mode_word_q [MAX_MODES];
  logic                        cfg_hit;
  logic [3:0]                  cnt_ext;
  logic [3:0]                  n_full;
  logic [JW-1:0]               n_eff;
  logic [CW-1:0]               last_idx;

  assign cfg_ready_o = 1'b1;
  assign cfg_hit     = cfg_valid_i && (cfg_index_i <= mpg_pkg::CFG_MODE_WORD_LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_count_q <= mpg_pkg::MODE_COUNT_RESET;
    end else if (cfg_valid_i && (cfg_index_i == mpg_pkg::CFG_MODE_COUNT)) begin
      mode_count_q <= cfg_data_i[2:0];
    end
  end

  for (genvar k = 0; k < MAX_MODES; k++) begin : g_word
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mode_word_q[k] <= mpg_pkg::MODE_WORD_RESET;
      end else if (cfg_hit &&
                   (int'(cfg_index_i) == k + int'(mpg_pkg::CFG_MODE_WORD_FIRST))) begin
        mode_word_q[k] <= cfg_data_i;
      end
    end
  end

  always_comb begin
    cnt_ext = {1'b0, mode_count_q};
    if (cnt_ext == 4'd0) begin
      n_full = 4'd1;
    end else if (cnt_ext > MAXM) begin
      n_full = MAXM;
    end else begin
      n_full = cnt_ext;
    end
    n_eff    = n_full[JW-1:0];
    last_idx = CW'(3 * int'(n_full) - 3);
  end

  // Corner table derivation.
  logic [3:0]                   state_q, state_d;
  logic [JW-1:0]                j_q, j_d;
  logic [CW-1:0]                base_q, base_d;
  logic [mpg_pkg::WORD_W-1:0]   w0_q, w0_d, w1_q, w1_d;
  logic signed [32:0]           p0_q, p0_d, p1_q, p1_d;
  logic [16:0]                  wsum_q, wsum_d;
  logic signed [15:0]           a_q, a_d;
  logic signed [15:0]           last_mean_q, last_mean_d;
  logic [15:0]                  last_inv_q, last_inv_d;

  logic signed [15:0]           m0, m1;
  logic [15:0]                  wd0, wd1, v0, v1;
  logic signed [mpg_pkg::DIVD_W-1:0] num;
  logic signed [16:0]           msum, bsum0, bsum1;

  logic                         cwr_en;
  logic [CW-1:0]                cwr_idx;
  mpg_pkg::corner_t             cwr;

  logic                         div_start;
  logic                         div_done;
  logic signed [15:0]           div_quot;

  assign m0  = w0_q[15:0];
  assign wd0 = w0_q[31:16];
  assign v0  = w0_q[47:32];
  assign m1  = w1_q[15:0];
  assign wd1 = w1_q[31:16];
  assign v1  = w1_q[47:32];

  assign num   = 34'(p0_q) + 34'(p1_q);
  assign msum  = {m0[15], m0} + {m1[15], m1};
  assign bsum0 = {m0[15], m0} + {a_q[15], a_q};
  assign bsum1 = {m1[15], m1} + {a_q[15], a_q};

  always_comb begin
    state_d     = state_q;
    j_d         = j_q;
    base_d      = base_q;
    w0_d        = w0_q;
    w1_d        = w1_q;
    p0_d        = p0_q;
    p1_d        = p1_q;
    wsum_d      = wsum_q;
    a_d         = a_q;
    last_mean_d = last_mean_q;
    last_inv_d  = last_inv_q;
    cwr_en      = 1'b0;
    cwr_idx     = base_q;
    cwr         = '0;
    div_start   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
      end
      S_START: begin
        w1_d    = mode_word_q[0];
        j_d     = JW'(1);
        base_d  = '0;
        state_d = S_NEXT;
      end
      S_NEXT: begin
        if (j_q == n_eff) begin
          cwr_en      = 1'b1;
          cwr.pos     = m1;
          cwr.ctr     = m1;
          cwr.slp     = {1'b0, v1};
          last_mean_d = m1;
          last_inv_d  = v1;
          state_d     = S_IDLE;
        end else begin
          w0_d    = w1_q;
          w1_d    = mode_word_q[j_q[IW-1:0]];
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        p0_d    = m0 * $signed({1'b0, wd1});
        p1_d    = m1 * $signed({1'b0, wd0});
        wsum_d  = {1'b0, wd0} + {1'b0, wd1};
        state_d = S_ADD;
      end
      S_ADD: begin
        if (wsum_q == '0) begin
          a_d     = msum[16:1];
          state_d = S_WR0;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          a_d     = div_quot;
          state_d = S_WR0;
        end
      end
      S_WR0: begin
        cwr_en  = 1'b1;
        cwr.pos = bsum0[16:1];
        cwr.ctr = m0;
        cwr.slp = {1'b0, v0};
        state_d = S_WR1;
      end
      S_WR1: begin
        cwr_en  = 1'b1;
        cwr_idx = base_q + CW'(1);
        cwr.pos = a_q;
        cwr.ctr = a_q;
        cwr.slp = 17'd0 - {1'b0, v0};
        state_d = S_WR2;
      end
      S_WR2: begin
        cwr_en  = 1'b1;
        cwr_idx = base_q + CW'(2);
        cwr.pos = bsum1[16:1];
        cwr.ctr = a_q;
        cwr.slp = 17'd0 - {1'b0, v1};
        base_d  = base_q + CW'(3);
        j_d     = j_q + JW'(1);
        state_d = S_NEXT;
      end
      default: begin
        state_d = S_START;
      end
    endcase
    if (cfg_hit) begin
      state_d = S_START;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_START;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q         <= j_d;
    base_q      <= base_d;
    w0_q        <= w0_d;
    w1_q        <= w1_d;
    p0_q        <= p0_d;
    p1_q        <= p1_d;
    wsum_q      <= wsum_d;
    a_q         <= a_d;
    last_mean_q <= last_mean_d;
    last_inv_q  <= last_inv_d;
  end

  mpg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (num),
    .divisor_i  (wsum_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Pixel path.
  logic                        adv;
  logic                        busy;
  mpg_pkg::stage_t             chain [NC+1];
  logic [NC-1:0]               cell_act;
  logic [NC-1:0]               cell_wr_en;
  logic signed [15:0]          pix;
  logic signed [15:0]          first_mean;

  logic                        mul_valid_q;
  logic                        mul_last_q;
  logic signed [33:0]          mul_prod_q;
  logic signed [16:0]          mul_slp_q;
  logic signed [16:0]          diff;
  logic signed [16:0]          slp_abs;

  logic                        out_valid_q;
  logic                        out_last_q;
  logic [mpg_pkg::GRAD_W-1:0]  grad_q;
  logic [mpg_pkg::CURV_W-1:0]  curv_q;
  logic [mpg_pkg::GRAD_W-1:0]  grad_sat;

  assign busy          = state_q != S_IDLE;
  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !busy && adv;
  assign pix           = s_axis_tdata;
  assign first_mean    = mode_word_q[0][15:0];

  always_comb begin
    chain[0].valid = s_axis_tvalid && s_axis_tready;
    chain[0].pixel = pix;
    chain[0].last  = s_axis_tlast;
    if (pix <= first_mean) begin
      chain[0].found = 1'b1;
      chain[0].ctr   = first_mean;
      chain[0].slp   = {1'b0, mode_word_q[0][47:32]};
    end else if (pix >= last_mean_q) begin
      chain[0].found = 1'b1;
      chain[0].ctr   = last_mean_q;
      chain[0].slp   = {1'b0, last_inv_q};
    end else begin
      chain[0].found = 1'b0;
      chain[0].ctr   = last_mean_q;
      chain[0].slp   = {1'b0, last_inv_q};
    end
  end

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      cell_act[c]   = c <= int'(last_idx);
      cell_wr_en[c] = cwr_en && (cwr_idx == CW'(c));
    end
  end

  for (genvar c = 0; c < NC; c++) begin : g_cell
    mpg_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .wr_en_i (cell_wr_en[c]),
      .wr_i    (cwr),
      .act_i   (cell_act[c]),
      .stage_i (chain[c]),
      .stage_o (chain[c+1])
    );
  end

  assign diff = {chain[NC].ctr[15], chain[NC].ctr} - {chain[NC].pixel[15], chain[NC].pixel};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      mul_valid_q <= chain[NC].valid;
      out_valid_q <= mul_valid_q;
    end
  end

  always_comb begin
    if (mul_prod_q[33:31] == 3'b000 || mul_prod_q[33:31] == 3'b111) begin
      grad_sat = mul_prod_q[31:0];
    end else if (mul_prod_q[33]) begin
      grad_sat = 32'h8000_0000;
    end else begin
      grad_sat = 32'h7FFF_FFFF;
    end
    slp_abs = mul_slp_q[16] ? (17'sd0 - mul_slp_q) : mul_slp_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mul_prod_q <= diff * chain[NC].slp;
      mul_slp_q  <= chain[NC].slp;
      mul_last_q <= chain[NC].last;
      grad_q     <= grad_sat;
      curv_q     <= slp_abs[15:0];
      out_last_q <= mul_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {curv_q, grad_q};
  assign m_axis_tlast  = out_last_q;

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (state_q == S_IDLE))
    else $error("pixel transaction offered while the corner table is rebuilt");

  a_cfg_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit |=> (state_q == S_START))
    else $error("configuration write did not restart the corner derivation");

  a_one_corner_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cell_wr_en))
    else $error("more than one corner cell written in a cycle");

  a_div_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> (state_q == S_DIV) || (state_q == S_START))
    else $error("divider started outside the division step");

endmodule

`default_nettype wire

@@ rtl/mpg_div.sv @@
// Restoring divider, one quotient bit per cycle, giving a floored signed quotient.
// Depends on mpg_pkg.
`default_nettype none

module mpg_div (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic signed [mpg_pkg::DIVD_W-1:0] dividend_i,
  input  wire logic        [mpg_pkg::DIVS_W-1:0] divisor_i,
  output logic                                   done_o,
  output logic signed [mpg_pkg::PIX_W-1:0]       quot_o
);

  localparam int CNT_W = $clog2(mpg_pkg::DIVD_W);

  logic                         run_q;
  logic                         done_q;
  logic [CNT_W-1:0]             cnt_q;
  logic [mpg_pkg::DIVD_W-1:0]   acc_q;
  logic [mpg_pkg::DIVS_W:0]     rem_q;
  logic [mpg_pkg::DIVS_W-1:0]   den_q;
  logic                         neg_q;

  logic [mpg_pkg::DIVD_W-1:0]   mag_in;
  logic [mpg_pkg::DIVS_W:0]     rem_sh;
  logic [mpg_pkg::DIVS_W:0]     rem_nx;
  logic                         ge;
  logic [mpg_pkg::DIVD_W:0]     q_ext;
  logic [mpg_pkg::DIVD_W:0]     q_res;

  assign mag_in = dividend_i[mpg_pkg::DIVD_W-1] ? (~dividend_i + 34'd1) : dividend_i;
  assign rem_sh = {rem_q[mpg_pkg::DIVS_W-1:0], acc_q[mpg_pkg::DIVD_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign rem_nx = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (run_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(mpg_pkg::DIVD_W - 1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= mag_in;
      rem_q <= '0;
      den_q <= divisor_i;
      neg_q <= dividend_i[mpg_pkg::DIVD_W-1];
    end else if (run_q) begin
      acc_q <= {acc_q[mpg_pkg::DIVD_W-2:0], ge};
      rem_q <= rem_nx;
    end
  end

  // A negative quotient with a remainder rounds one further down.
  assign q_ext  = {1'b0, acc_q};
  assign q_res  = neg_q ? (~q_ext + 35'd1 - 35'(rem_q != '0)) : q_ext;
  assign quot_o = q_res[mpg_pkg::PIX_W-1:0];
  assign done_o = done_q;

endmodule

`default_nettype wire

@@ rtl/mpg_cell.sv @@
// One corner cell of the search chain: holds a corner and passes the pixel on.
// Depends on mpg_pkg.
`default_nettype none

module mpg_cell (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             adv_i,
  input  wire logic             wr_en_i,
  input  wire mpg_pkg::corner_t wr_i,
  input  wire logic             act_i,
  input  wire mpg_pkg::stage_t  stage_i,
  output mpg_pkg::stage_t       stage_o
);

  mpg_pkg::corner_t corner_q;
  mpg_pkg::stage_t  stage_d;
  mpg_pkg::stage_t  stage_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      corner_q <= wr_i;
    end
  end

  always_comb begin
    stage_d = stage_i;
    if (act_i && !stage_i.found && ($signed(corner_q.pos) >= $signed(stage_i.pixel))) begin
      stage_d.found = 1'b1;
      stage_d.ctr   = corner_q.ctr;
      stage_d.slp   = corner_q.slp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (adv_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

`default_nettype wire

@@ tb/multimodal_prior_gradient_core_test.sv @@
// Self-checking testbench for multimodal_prior_gradient_core: directed and random pixel
// streams under several mode settings, checked against an in-bench gradient predictor.
// Depends on mpg_pkg and the core RTL only.
`timescale 1ns / 100ps

module multimodal_prior_gradient_core_test;
  import mpg_pkg::*;

  localparam int MODES          = 4;
  localparam int CORNERS        = 3 * MODES - 2;
  localparam int LATENCY        = 3 * MODES;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam longint GRAD_MAX   = (64'sd1 <<< 31) - 1;
  localparam longint GRAD_MIN   = -(64'sd1 <<< 31);

  localparam logic [CFG_IDX_W-1:0] CFG_BEYOND_FIRST = CFG_MODE_WORD_LAST + 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BEYOND_LAST  = '1;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gradient;
    logic [CURV_W-1:0]        curvature;
    logic                     last;
  } grad_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [WORD_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [PIX_W-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [GRAD_W+CURV_W-1:0] m_axis_tdata;
  logic m_axis_tlast;

  logic [2:0] mode_total;
  logic [WORD_W-1:0] mode_reg [MODES];
  logic [WORD_W-1:0] plan_word [MODES];
  int crn_pos [CORNERS];
  int crn_ctr [CORNERS];
  int crn_slp [CORNERS];

  grad_result_t expected_gradients [$];
  int mismatches = 0;
  int quiet_cycles = 0;
  int unsigned rx_hold = 0;
  bit idle_on = 1'b1;

  multimodal_prior_gradient_core #(
    .MAX_MODES(MODES)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  function automatic int used_modes();
    if (mode_total == 3'd0) return 1;
    if (mode_total > MODES) return MODES;
    return int'(mode_total);
  endfunction

  function automatic int mean_of(int k);
    return int'($signed(mode_reg[k][15:0]));
  endfunction

  function automatic longint width_of(int k);
    return longint'(mode_reg[k][31:16]);
  endfunction

  function automatic int inv_of(int k);
    return int'(mode_reg[k][47:32]);
  endfunction

  function automatic longint floor_quot(longint num, longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    return q;
  endfunction

  function automatic void rebuild_corners();
    int n;
    int b;
    longint m0, m1, w0, w1, wsum, a;
    n = used_modes();
    for (int i = 0; i < CORNERS; i++) begin
      crn_pos[i] = 0;
      crn_ctr[i] = 0;
      crn_slp[i] = 0;
    end
    for (int i = 0; i + 1 < n; i++) begin
      m0 = mean_of(i);
      m1 = mean_of(i + 1);
      w0 = width_of(i);
      w1 = width_of(i + 1);
      wsum = w0 + w1;
      a = (wsum != 0) ? floor_quot(m0 * w1 + m1 * w0, wsum) : floor_quot(m0 + m1, 2);
      b = 3 * i;
      crn_pos[b]     = int'(floor_quot(m0 + a, 2));
      crn_pos[b + 1] = int'(a);
      crn_pos[b + 2] = int'(floor_quot(m1 + a, 2));
      crn_ctr[b]     = int'(m0);
      crn_ctr[b + 1] = int'(a);
      crn_ctr[b + 2] = int'(a);
      crn_slp[b]     = inv_of(i);
      crn_slp[b + 1] = -inv_of(i);
      crn_slp[b + 2] = -inv_of(i + 1);
    end
    b = 3 * (n - 1);
    crn_pos[b] = mean_of(n - 1);
    crn_ctr[b] = mean_of(n - 1);
    crn_slp[b] = inv_of(n - 1);
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] value);
    if (idx == CFG_MODE_COUNT) begin
      mode_total = value[2:0];
      rebuild_corners();
    end else if (idx >= CFG_MODE_WORD_FIRST && idx <= CFG_MODE_WORD_LAST) begin
      mode_reg[idx - CFG_MODE_WORD_FIRST] = value;
      rebuild_corners();
    end
  endfunction

  function automatic grad_result_t predict_gradient(logic [PIX_W-1:0] pix, logic last);
    grad_result_t r;
    int n, p, lo, hi, c, s, k, top, mag;
    longint g;
    n = used_modes();
    p = int'($signed(pix));
    lo = mean_of(0);
    hi = mean_of(n - 1);
    if (p <= lo) begin
      c = lo;
      s = inv_of(0);
    end else if (p >= hi) begin
      c = hi;
      s = inv_of(n - 1);
    end else begin
      top = 3 * (n - 1);
      k = top;
      for (int i = top; i >= 0; i--) begin
        if (crn_pos[i] >= p) k = i;
      end
      c = crn_ctr[k];
      s = crn_slp[k];
    end
    g = longint'(c - p) * longint'(s);
    if (g > GRAD_MAX) g = GRAD_MAX;
    if (g < GRAD_MIN) g = GRAD_MIN;
    mag = (s < 0) ? -s : s;
    r.gradient = g[GRAD_W-1:0];
    r.curvature = mag[CURV_W-1:0];
    r.last = last;
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] mode_word(int mean, int width, int inv);
    return {16'(inv), 16'(width), 16'(mean)};
  endfunction

  function automatic logic [15:0] random_width();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return 16'($urandom);
      default: return 16'($urandom_range(1, 1024));
    endcase
  endfunction

  function automatic logic [15:0] random_inv();
    return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1024));
  endfunction

  function automatic logic [PIX_W-1:0] random_pixel();
    int n, lo, hi, v;
    n = used_modes();
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = mean_of($urandom_range(0, n - 1)) + $urandom_range(0, 4) - 2;
      2: v = crn_pos[$urandom_range(0, 3 * n - 3)] + $urandom_range(0, 4) - 2;
      default: begin
        lo = mean_of(0);
        hi = mean_of(n - 1);
        v = (lo <= hi) ? lo + $urandom_range(0, hi - lo) : $urandom;
      end
    endcase
    return v[PIX_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input longint want, input longint got);
    mismatches++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic last);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= pix;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_gradients.push_back(predict_gradient(pix, last));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_gradients.size() != 0) @(posedge clk_i);
  endtask

  task automatic wait_quiet();
    wait_drained();
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_register(idx, value);
  endtask

  task automatic write_single(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
    wait_quiet();
    write_register(idx, value);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_modes(input logic [2:0] count);
    wait_quiet();
    for (int k = 0; k < MODES; k++)
      write_register(CFG_MODE_WORD_FIRST + CFG_IDX_W'(k), plan_word[k]);
    write_register(CFG_MODE_COUNT, WORD_W'(count));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_plan();
    int means [$];
    bit narrow;
    narrow = ($urandom_range(0, 2) == 0);
    for (int k = 0; k < MODES; k++)
      means.push_back(narrow ? int'($urandom_range(0, 2048)) - 1024 : int'($signed(16'($urandom))));
    if ($urandom_range(0, 4) != 0) means.sort();
    for (int k = 0; k < MODES; k++)
      plan_word[k] = {random_inv(), random_width(), 16'(means[k])};
  endtask

  task automatic test_reset_state();
    send_pixel(16'h8000, 1'b0);
    send_pixel(16'h7FFF, 1'b0);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'h0001, 1'b1);
  endtask

  task automatic test_mode_layout();
    plan_word[0] = mode_word(-16384, 16'h0100, 16'h0100);
    plan_word[1] = mode_word(-2048, 16'h0300, 16'h0040);
    plan_word[2] = mode_word(2048, 16'h0080, 16'h0200);
    plan_word[3] = mode_word(16384, 16'h0200, 16'h0080);
    load_modes(3'd4);
    send_pixel(16'h8000, 1'b0);
    send_pixel(16'(-16384), 1'b0);
    send_pixel(16'(-16383), 1'b0);
    for (int k = 0; k < CORNERS - 1; k++) send_pixel(16'(crn_pos[k]), 1'b0);
    send_pixel(16'(16383), 1'b0);
    send_pixel(16'h7FFF, 1'b1);
  endtask

  task automatic test_mode_count_limits();
    write_single(CFG_MODE_COUNT, WORD_W'(3'd0));
    send_pixel(16'd100, 1'b0);
    write_single(CFG_MODE_COUNT, WORD_W'(3'd7));
    send_pixel(16'd0, 1'b1);
  endtask

  task automatic test_zero_width_sum();
    plan_word[0] = mode_word(-1001, 0, 16'h0100);
    plan_word[1] = mode_word(1000, 0, 16'h0080);
    load_modes(3'd2);
    send_pixel(16'd0, 1'b0);
    send_pixel(16'(-600), 1'b1);
  endtask

  task automatic test_unsorted_means();
    plan_word[0] = mode_word(0, 16'h0100, 16'h0100);
    plan_word[1] = mode_word(3000, 16'h0080, 16'h0200);
    plan_word[2] = mode_word(1000, 16'h0200, 16'h0040);
    load_modes(3'd3);
    send_pixel(16'd1500, 1'b0);
    send_pixel(16'd2500, 1'b1);
  endtask

  task automatic test_unused_index();
    write_single(CFG_BEYOND_FIRST, 48'hFFFF_FFFF_FFFF);
    write_single(CFG_BEYOND_LAST, 48'h1234_5678_9ABC);
    send_pixel(16'd500, 1'b1);
  endtask

  task automatic test_saturation();
    plan_word[0] = mode_word(32767, 16'hFFFF, 16'hFFFF);
    load_modes(3'd1);
    send_pixel(16'h8000, 1'b0);
    plan_word[0] = mode_word(-32768, 0, 16'hFFFF);
    load_modes(3'd1);
    send_pixel(16'h7FFF, 1'b1);
  endtask

  task automatic test_random_traffic();
    logic [2:0] count;
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 0) begin
        for (int k = 0; k < MODES; k++) plan_word[k] = '1;
        count = 3'd4;
      end else if (ph == 1) begin
        for (int k = 0; k < MODES; k++) plan_word[k] = '0;
        count = 3'd7;
      end else begin
        random_plan();
        count = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                            : 3'($urandom_range(2, 4));
      end
      load_modes(count);
      for (int i = 0; i < 110; i++) begin
        if (ph == 4 && i == 55) wait_drained();
        send_pixel(random_pixel(), $urandom_range(0, 15) == 0);
      end
    end
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    random_plan();
    load_modes(3'd4);
    for (int i = 0; i < 120; i++) send_pixel(random_pixel(), $urandom_range(0, 15) == 0);
  endtask

  always @(posedge clk_i) begin
    if (rx_hold == 0 && idle_on && $urandom_range(0, 5) == 0) rx_hold = $urandom_range(1, 8);
    if (rx_hold != 0) begin
      rx_hold--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    grad_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_gradients.size() == 0) begin
        report_mismatch("unexpected result", 0, longint'(m_axis_tdata));
      end else begin
        want = expected_gradients.pop_front();
        if (m_axis_tdata[GRAD_W-1:0] !== want.gradient)
          report_mismatch("gradient", want.gradient, $signed(m_axis_tdata[GRAD_W-1:0]));
        if (m_axis_tdata[GRAD_W+CURV_W-1:GRAD_W] !== want.curvature)
          report_mismatch("curvature", want.curvature, m_axis_tdata[GRAD_W+CURV_W-1:GRAD_W]);
        if (m_axis_tlast !== want.last)
          report_mismatch("last flag", want.last, m_axis_tlast);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    mode_total = MODE_COUNT_RESET;
    for (int k = 0; k < MODES; k++) mode_reg[k] = MODE_WORD_RESET;
    rebuild_corners();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_mode_layout();
    test_mode_count_limits();
    test_zero_width_sum();
    test_unsorted_means();
    test_unused_index();
    test_saturation();
    test_random_traffic();
    test_steady_stream();
    wait_quiet();
    if (mismatches == 0 && expected_gradients.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
